/* hw/rtl/mm64a_pkg.sv */
package mm64a_pkg;

    // Word and half-word widths of the datapath.
    localparam int unsigned WordW = 64;
    localparam int unsigned HalfW = 32;

    typedef logic [WordW-1:0] word_t;
    typedef logic [HalfW-1:0] half_t;

    // MurmurHash64A multiplier and shift distance.
    localparam word_t MUR_M = 64'hc6a4a7935bd1e995;
    localparam int unsigned MUR_R = 47;

    // Keeps the low nbytes bytes of a tail word; nbytes of zero keeps nothing.
    function automatic word_t tail_mask(input logic [2:0] nbytes);
        word_t mask;
        unique case (nbytes)
            3'd0:    mask = 64'h0000_0000_0000_0000;
            3'd1:    mask = 64'h0000_0000_0000_00ff;
            3'd2:    mask = 64'h0000_0000_0000_ffff;
            3'd3:    mask = 64'h0000_0000_00ff_ffff;
            3'd4:    mask = 64'h0000_0000_ffff_ffff;
            3'd5:    mask = 64'h0000_00ff_ffff_ffff;
            3'd6:    mask = 64'h0000_ffff_ffff_ffff;
            3'd7:    mask = 64'h00ff_ffff_ffff_ffff;
            default: mask = 64'h0000_0000_0000_0000;
        endcase
        return mask;
    endfunction

    // Xor of a word with itself shifted right by the mixing distance.
    function automatic word_t xor_shift(input word_t w);
        return w ^ (w >> MUR_R);
    endfunction

endpackage

/* hw/rtl/mm64a_mul.sv */
module mm64a_mul (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  mm64a_pkg::word_t     a,
    input  mm64a_pkg::word_t     b,
    output logic                 done,
    output mm64a_pkg::word_t     p
);

    // Sequencer steps: three partial products, then a final accumulate.
    localparam logic [2:0] STEP_IDLE = 3'd0;
    localparam logic [2:0] STEP_LL   = 3'd1;
    localparam logic [2:0] STEP_LH   = 3'd2;
    localparam logic [2:0] STEP_HL   = 3'd3;
    localparam logic [2:0] STEP_SUM  = 3'd4;

    logic [2:0]        step_reg;
    logic [2:0]        step_next;
    logic              done_reg;
    logic              done_next;
    mm64a_pkg::word_t  a_reg;
    mm64a_pkg::word_t  b_reg;
    mm64a_pkg::word_t  prod_reg;
    mm64a_pkg::word_t  prod_next;
    mm64a_pkg::word_t  acc_reg;
    mm64a_pkg::word_t  acc_next;
    mm64a_pkg::half_t  op_x;
    mm64a_pkg::half_t  op_y;

    // Operand selection for the single 32 by 32 multiplier.
    always_comb
    begin
        unique case (step_reg)
            STEP_LL:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[31:0];
            end
            STEP_LH:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[63:32];
            end
            STEP_HL:
            begin
                op_x = a_reg[63:32];
                op_y = b_reg[31:0];
            end
            default:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[31:0];
            end
        endcase
        prod_next = 64'(op_x) * 64'(op_y);
    end

    // Accumulation of the registered partial products, modulo 2^64.
    always_comb
    begin
        acc_next  = acc_reg;
        step_next = step_reg;
        done_next = 1'b0;
        unique case (step_reg)
            STEP_IDLE:
            begin
                if (start)
                begin
                    step_next = STEP_LL;
                end
            end
            STEP_LL:
            begin
                step_next = STEP_LH;
            end
            STEP_LH:
            begin
                acc_next  = prod_reg;
                step_next = STEP_HL;
            end
            STEP_HL:
            begin
                acc_next  = acc_reg + {prod_reg[31:0], 32'h0000_0000};
                step_next = STEP_SUM;
            end
            STEP_SUM:
            begin
                acc_next  = acc_reg + {prod_reg[31:0], 32'h0000_0000};
                step_next = STEP_IDLE;
                done_next = 1'b1;
            end
            default:
            begin
                step_next = STEP_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    // Operand and product registers.
    always_ff @(posedge clk)
    begin
        if (start && (step_reg == STEP_IDLE))
        begin
            a_reg <= a;
            b_reg <= b;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

/* hw/rtl/murmur64a_stream_hash.sv */
// Streaming MurmurHash64A (seed zero) over little-endian 64-bit words. Every
// 64-bit multiply runs on one shared 32 by 32 multiplier as three partial
// products, so the cost of an item follows from the number of multiplies it
// needs. A full word needs three multiplies, a tail word one and an empty word
// none. A first item adds a multiply for the length seed, and a last item adds
// finalisation, plus any wait for the output register. The block takes one
// transaction at a time and drops in_ready until it is done; a finished hash
// waits in an output register so that the next message may start while it is
// still unread.
module murmur64a_stream_hash (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [63:0]  data_word,
    input  logic [3:0]   byte_count,
    input  logic         first_item,
    input  logic         last_item,
    input  logic [31:0]  total_length,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [63:0]  hash_value
);

    // Sequencer states.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SEED = 4'd1;
    localparam logic [3:0] ST_DISP = 4'd2;
    localparam logic [3:0] ST_W1   = 4'd3;
    localparam logic [3:0] ST_W2   = 4'd4;
    localparam logic [3:0] ST_HMUL = 4'd5;
    localparam logic [3:0] ST_END  = 4'd6;
    localparam logic [3:0] ST_FIN  = 4'd7;
    localparam logic [3:0] ST_PUT  = 4'd8;

    logic [3:0]        state_reg;
    logic [3:0]        state_next;
    mm64a_pkg::word_t  hash_reg;
    mm64a_pkg::word_t  hash_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    mm64a_pkg::word_t  out_hash_reg;
    mm64a_pkg::word_t  out_hash_next;
    mm64a_pkg::word_t  word_reg;
    logic [3:0]        count_reg;
    logic              last_reg;
    logic              in_accept;
    logic              out_load;
    logic              mul_start;
    logic              mul_done;
    mm64a_pkg::word_t  mul_a;
    mm64a_pkg::word_t  mul_p;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_load  = (state_reg == ST_PUT) && (!out_valid_reg || out_ready);

    // Shared multiplier; the second operand is always the mixing constant.
    mm64a_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mm64a_pkg::MUR_M),
        .done  (mul_done),
        .p     (mul_p)
    );

    // Operand choice and issue of each multiply.
    always_comb
    begin
        mul_a     = '0;
        mul_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                mul_a     = {32'h0000_0000, total_length};
                mul_start = in_accept && first_item;
            end
            ST_DISP:
            begin
                if (count_reg[3])
                begin
                    mul_a = word_reg;
                end
                else
                begin
                    mul_a = hash_reg ^ (word_reg & mm64a_pkg::tail_mask(count_reg[2:0]));
                end
                mul_start = (count_reg != 4'd0);
            end
            ST_W1:
            begin
                mul_a     = mm64a_pkg::xor_shift(mul_p);
                mul_start = mul_done;
            end
            ST_W2:
            begin
                mul_a     = hash_reg ^ mul_p;
                mul_start = mul_done;
            end
            ST_END:
            begin
                mul_a     = mm64a_pkg::xor_shift(hash_reg);
                mul_start = last_reg;
            end
            default:
            begin
                mul_a     = '0;
                mul_start = 1'b0;
            end
        endcase
    end

    // Sequencer and running hash.
    always_comb
    begin
        state_next = state_reg;
        hash_next  = hash_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = first_item ? ST_SEED : ST_DISP;
                end
            end
            ST_SEED:
            begin
                if (mul_done)
                begin
                    hash_next  = mul_p;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                if (count_reg[3])
                begin
                    state_next = ST_W1;
                end
                else if (count_reg != 4'd0)
                begin
                    state_next = ST_HMUL;
                end
                else
                begin
                    state_next = ST_END;
                end
            end
            ST_W1:
            begin
                if (mul_done)
                begin
                    state_next = ST_W2;
                end
            end
            ST_W2:
            begin
                if (mul_done)
                begin
                    state_next = ST_HMUL;
                end
            end
            ST_HMUL:
            begin
                if (mul_done)
                begin
                    hash_next  = mul_p;
                    state_next = ST_END;
                end
            end
            ST_END:
            begin
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                if (mul_done)
                begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: the finalised hash waits here until it is taken.
    always_comb
    begin
        out_hash_next  = out_hash_reg;
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_hash_next  = mm64a_pkg::xor_shift(mul_p);
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state and running hash.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hash_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Captured transaction fields and the result payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            word_reg  <= data_word;
            count_reg <= byte_count;
            last_reg  <= last_item;
        end
        out_hash_reg <= out_hash_next;
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = out_hash_reg;

    // A multiply only completes while the sequencer is waiting for one.
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_SEED || state_reg == ST_W1 || state_reg == ST_W2 ||
                      state_reg == ST_HMUL || state_reg == ST_FIN))
        else $error("multiplier result arrived outside a wait state");

    // A new result is only loaded from the output hand-over state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_PUT))
        else $error("result raised outside the hand-over state");

    // An accepted transaction always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after accepting a transaction");

    // The multiplier is never restarted while the sequencer waits for it in the seed, hash or final state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN || state_reg == ST_SEED || state_reg == ST_HMUL) |-> !mul_start)
        else $error("multiply issued while a previous one is pending");

endmodule

/* verif/murmur64a_hash_checker.sv */
// Watches both channels of the stream hasher, keeps its own copy of the
// running hash and compares every emitted hash with the oldest one predicted.
module murmur64a_hash_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  mm64a_pkg::word_t  data_word,
    input  logic [3:0]        byte_count,
    input  logic              first_item,
    input  logic              last_item,
    input  logic [31:0]       total_length,
    input  logic              out_valid,
    input  logic              out_ready,
    input  mm64a_pkg::word_t  hash_value,
    output int                results_owed,
    output int                mismatch_count
);

    localparam logic [63:0] HashMul   = 64'hc6a4a7935bd1e995;
    localparam int          HashShift = 47;

    logic [63:0] running_hash;
    logic [63:0] expected_hashes[$];

    // Folds one word into the hash: a full word is mixed, a short one is
    // masked to its valid bytes, and a word with no bytes leaves the hash alone.
    function automatic logic [63:0] absorb_word(input logic [63:0] h, input logic [63:0] w,
                                                input logic [3:0] n);
        logic [63:0] k;
        logic [63:0] keep;
        if (n >= 4'd8)
        begin
            k = w * HashMul;
            k = k ^ (k >> HashShift);
            k = k * HashMul;
            return (h ^ k) * HashMul;
        end
        if (n == 4'd0)
        begin
            return h;
        end
        keep = (64'd1 << (8 * n)) - 64'd1;
        return (h ^ (w & keep)) * HashMul;
    endfunction

    // Final avalanche applied to the hash of a complete message.
    function automatic logic [63:0] finish_hash(input logic [63:0] h);
        logic [63:0] f;
        f = h ^ (h >> HashShift);
        f = f * HashMul;
        return f ^ (f >> HashShift);
    endfunction

    // Results are retired before inputs are absorbed, as a result can never
    // come from a transaction accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        logic [63:0] next_hash;
        logic [63:0] oldest;
        if (!rst_n)
        begin
            running_hash <= '0;
            expected_hashes.delete();
            results_owed <= 0;
            mismatch_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_hashes.size() == 0)
                begin
                    $error("hash_value %h arrived while no hash was expected", hash_value);
                    mismatch_count++;
                end
                else
                begin
                    oldest = expected_hashes.pop_front();
                    if (hash_value !== oldest)
                    begin
                        $error("hash_value mismatch: expected %h, actual %h", oldest, hash_value);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                next_hash = first_item ? {32'd0, total_length} * HashMul : running_hash;
                next_hash = absorb_word(next_hash, data_word, byte_count);
                running_hash <= next_hash;
                if (last_item)
                begin
                    expected_hashes.push_back(finish_hash(next_hash));
                end
            end
            results_owed <= expected_hashes.size();
        end
    end

endmodule

/* verif/tb_murmur64a_stream_hash.sv */
// Drives messages into the stream hasher and gives the verdict; all checking
// is done by the checker instantiated beside the block.
module tb_murmur64a_stream_hash;

    localparam int ClockPeriod = 12;
    localparam int CycleLimit  = 500000;
    localparam int RandomItems = 750;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_ready;
    mm64a_pkg::word_t  data_word    = '0;
    logic [3:0]        byte_count   = '0;
    logic              first_item   = 1'b0;
    logic              last_item    = 1'b0;
    logic [31:0]       total_length = '0;
    logic              out_valid;
    logic              out_ready    = 1'b0;
    mm64a_pkg::word_t  hash_value;

    int results_owed;
    int mismatch_count;
    int burst_left    = 0;
    int items_offered = 0;
    int cycle_count   = 0;

    murmur64a_stream_hash dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_word    (data_word),
        .byte_count   (byte_count),
        .first_item   (first_item),
        .last_item    (last_item),
        .total_length (total_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hash_value   (hash_value)
    );

    murmur64a_hash_checker hash_monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_word      (data_word),
        .byte_count     (byte_count),
        .first_item     (first_item),
        .last_item      (last_item),
        .total_length   (total_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hash_value     (hash_value),
        .results_owed   (results_owed),
        .mismatch_count (mismatch_count)
    );

    initial
    begin
        forever #(ClockPeriod / 2) clk = ~clk;
    end

    // Guards against a hung handshake.
    initial
    begin
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // Offers one transaction; the sender works in bursts separated by gaps.
    task automatic offer_item(input mm64a_pkg::word_t w, input logic [3:0] n, input logic f,
                              input logic l, input logic [31:0] len);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 15);
            if (in_valid)
            begin
                in_valid <= 1'b0;
            end
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        in_valid     <= 1'b1;
        data_word    <= w;
        byte_count   <= n;
        first_item   <= f;
        last_item    <= l;
        total_length <= len;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_offered++;
    endtask

    // Holds the sender off until every predicted hash has been delivered.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        burst_left = 0;
    endtask

    // Sends a well-formed message of msg_len bytes split into words; stray
    // bytes above the valid ones are left in the final word when asked.
    task automatic send_message(input int msg_len, input logic [31:0] stated_len,
                                input bit stray);
        int words;
        int k;
        int rest;
        logic [3:0] n;
        mm64a_pkg::word_t w;
        logic [31:0] len;
        words = (msg_len == 0) ? 1 : (msg_len + 7) / 8;
        for (k = 0; k < words; k++)
        begin
            rest = msg_len - 8 * k;
            n = (rest >= 8) ? 4'd8 : rest[3:0];
            w = {$urandom, $urandom};
            if (n < 4'd8 && !stray)
            begin
                w = w & ((64'd1 << (8 * n)) - 64'd1);
            end
            len = (k == 0) ? stated_len : $urandom;
            offer_item(w, n, k == 0, k == words - 1, len);
        end
    endtask

    // The receiver alternates between always ready, random stalls and, now
    // and then, a long hold-off that backs the block up into its input.
    initial
    begin : receiver
        int epoch;
        int span;
        int mode;
        wait (rst_n === 1'b1);
        @(posedge clk);
        epoch = 0;
        forever
        begin
            epoch++;
            if (epoch == 15 || $urandom_range(0, 19) == 0)
            begin
                out_ready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(30, 250);
                repeat (span)
                begin
                    case (mode)
                        0:       out_ready <= 1'b1;
                        1:       out_ready <= 1'($urandom_range(0, 1));
                        default: out_ready <= ($urandom_range(0, 7) != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        int random_start;
        int msg_len;
        logic [31:0] stated;
        bit stray;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty messages, with the smallest and largest length seeds.
        offer_item(64'h0, 4'd0, 1'b1, 1'b1, 32'h0);
        offer_item('1, 4'd0, 1'b1, 1'b1, 32'hffff_ffff);
        // Single full words at both data extremes.
        offer_item('1, 4'd8, 1'b1, 1'b1, 32'd8);
        offer_item(64'h0, 4'd8, 1'b1, 1'b1, 32'd8);
        // Shortest and longest tails, with stray bytes above the valid ones.
        offer_item(64'hffff_ffff_ffff_ff5a, 4'd1, 1'b1, 1'b1, 32'd1);
        offer_item(64'ha5ff_eedd_ccbb_aa99, 4'd7, 1'b1, 1'b1, 32'd7);
        // Byte counts above eight count as a full word.
        offer_item(64'h8000_0000_0000_0001, 4'd15, 1'b1, 1'b1, 32'hffff_ffff);
        offer_item(64'h0123_4567_89ab_cdef, 4'd9, 1'b1, 1'b1, 32'd9);
        // Full word followed by a tail.
        offer_item(64'h0706_0504_0302_0100, 4'd8, 1'b1, 1'b0, 32'd11);
        offer_item(64'h0000_0000_000a_0908, 4'd3, 1'b0, 1'b1, 32'd11);
        // Short word before the last one.
        offer_item(64'h0000_0000_dead_beef, 4'd4, 1'b1, 1'b0, 32'd12);
        offer_item(64'hfedc_ba98_7654_3210, 4'd8, 1'b0, 1'b1, 32'd12);
        // Empty word in the middle of a message.
        offer_item(64'h5555_aaaa_5555_aaaa, 4'd8, 1'b1, 1'b0, 32'd16);
        offer_item('1, 4'd0, 1'b0, 1'b0, 32'd16);
        offer_item(64'haaaa_5555_aaaa_5555, 4'd8, 1'b0, 1'b1, 32'd16);
        // Messages without a first item carry on from the kept hash.
        offer_item(64'h1122_3344_5566_7788, 4'd8, 1'b0, 1'b1, 32'h1234_5678);
        offer_item(64'h0000_00ab_cdef_0123, 4'd5, 1'b0, 1'b1, 32'h0);
        // A second first item restarts the message.
        offer_item(64'h0f0f_0f0f_0f0f_0f0f, 4'd8, 1'b1, 1'b0, 32'd100);
        offer_item(64'h0000_0000_0000_beef, 4'd2, 1'b1, 1'b1, 32'd2);
        // Stated length that disagrees with the data.
        offer_item(64'h7fff_ffff_ffff_fffe, 4'd8, 1'b1, 1'b1, 32'h0);
        drain_results();

        // Mostly well-formed messages with random content, some noise.
        random_start = items_offered;
        while (items_offered - random_start < RandomItems)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                msg_len = ($urandom_range(0, 4) == 0) ? $urandom_range(41, 160)
                                                      : $urandom_range(0, 40);
                stated = ($urandom_range(0, 9) < 8) ? 32'(msg_len) : 32'($urandom);
                stray = ($urandom_range(0, 4) == 0);
                send_message(msg_len, stated, stray);
            end
            else
            begin
                offer_item({$urandom, $urandom}, 4'($urandom_range(0, 15)),
                           ($urandom_range(0, 2) == 0), ($urandom_range(0, 2) == 0),
                           32'($urandom));
            end
            if ($urandom_range(0, 39) == 0)
            begin
                drain_results();
            end
        end

        drain_results();
        repeat (60) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
